// File: rtl/tddq_pkg.sv
// tddq_pkg: shared constants, codes and types of the trace driven delay queue
// used by the controller, the datapath and the top level
`default_nettype none

package tddq_pkg;

   // storage sizes
   localparam int TABLE_DEPTH = 1024;
   localparam int QUEUE_DEPTH = 32;
   localparam int TIDX_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int TIME_W  = 48;
   localparam int ID_W    = 16;
   localparam int DLY_W   = 16;
   localparam int EIDX_W  = 10;
   localparam int IV_W    = 16;
   localparam int ENT_W   = 11;
   localparam int ORD_W   = 32;
   localparam int WAIT_W  = 16;
   localparam int KIND_W  = 3;
   localparam int RTYPE_W = 2;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 48;
   localparam int REQ_D_W = 96;
   localparam int RSP_D_W = 32;

   // divider sequence length and controller counter width
   localparam int DIV_STEPS = TIME_W;
   localparam int CTR_W     = 6;

   localparam logic [WAIT_W-1:0] WAIT_EMPTY = '1;

   // request kinds
   localparam logic [RTYPE_W-1:0] REQ_LOAD    = 2'd0;
   localparam logic [RTYPE_W-1:0] REQ_ARRIVAL = 2'd1;
   localparam logic [RTYPE_W-1:0] REQ_POLL    = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_LOADED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd4;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_BASE     = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_ENTRIES  = 2'd2;

   // one queued packet
   typedef struct packed {
      logic [TIME_W-1:0] rel;
      logic [ID_W-1:0]   id;
      logic [ORD_W-1:0]  order;
   } q_entry_type;

   // controller to datapath
   typedef struct packed {
      logic              latch;
      logic              tbl_wr;
      logic              div_init;
      logic              div_step;
      logic              tbl_rd;
      logic              q_push;
      logic              q_rd;
      logic              scan_cmp;
      logic [QIDX_W-1:0] q_addr;
      logic              q_move;
      logic              emit;
      logic [KIND_W-1:0] emit_kind;
      logic              emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OCC_W-1:0] occ;
      logic             full;
      logic             due;
      logic             out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/tddq_datapath.sv
// tddq_datapath: request latch, config registers, bit-serial divider, delay table,
// packet queue memory, head scan and result register; depends on tddq_pkg
`default_nettype none

module tddq_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [tddq_pkg::CSR_A_W-1:0]   csr_addr,
   input  wire logic [tddq_pkg::CSR_D_W-1:0]   csr_wdata,
   input  wire logic [tddq_pkg::REQ_D_W-1:0]   req_tdata,
   input  wire tddq_pkg::cmd_type              cmd,
   output tddq_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [tddq_pkg::RSP_D_W-1:0]        rsp_tdata,
   output logic [tddq_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                                rsp_tlast
);
   import tddq_pkg::*;

   // config registers
   logic [IV_W-1:0]   interval_ff;
   logic [TIME_W-1:0] base_ff;
   logic [ENT_W-1:0]  entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IV_W'(1);
         base_ff     <= '0;
         entries_ff  <= ENT_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_INTERVAL: interval_ff <= csr_wdata[IV_W-1:0];
            CSR_BASE:     base_ff     <= csr_wdata[TIME_W-1:0];
            CSR_ENTRIES:  entries_ff  <= csr_wdata[ENT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective divisor and entry count
   logic [IV_W-1:0]  iv_eff;
   logic [CNT_W-1:0] cnt_eff;

   always_comb begin
      iv_eff = (interval_ff == '0) ? IV_W'(1) : interval_ff;
      if (entries_ff == '0)
         cnt_eff = CNT_W'(1);
      else if (32'(entries_ff) > TABLE_DEPTH)
         cnt_eff = CNT_W'(TABLE_DEPTH);
      else
         cnt_eff = CNT_W'(entries_ff);
   end

   // request latch
   logic [TIME_W-1:0] now_ff;
   logic [ID_W-1:0]   pid_ff;
   logic [DLY_W-1:0]  dval_ff;
   logic [EIDX_W-1:0] eidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         now_ff  <= req_tdata[TIME_W-1:0];
         pid_ff  <= req_tdata[TIME_W +: ID_W];
         dval_ff <= req_tdata[TIME_W+ID_W +: DLY_W];
         eidx_ff <= req_tdata[TIME_W+ID_W+DLY_W +: EIDX_W];
      end
   end

   // restoring divider by interval, quotient reduced mod entry count bit by bit
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [IV_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]  mod_ff, mod_in;
   logic [IV_W:0]     rem_sh;
   logic              qbit;
   logic [CNT_W-1:0]  mod_sh;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[TIME_W-1]};
      qbit   = rem_sh >= {1'b0, iv_eff};
      rem_in = qbit ? IV_W'(rem_sh - {1'b0, iv_eff}) : rem_sh[IV_W-1:0];
      dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
      mod_sh = {mod_ff[CNT_W-2:0], qbit};
      mod_in = (mod_sh >= cnt_eff) ? mod_sh - cnt_eff : mod_sh;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff <= (now_ff >= base_ff) ? now_ff - base_ff : '0;
         rem_ff <= '0;
         mod_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         mod_ff <= mod_in;
      end
   end

   // delay table memory
   logic [DLY_W-1:0] tbl_mem [TABLE_DEPTH];
   logic [DLY_W-1:0] tbl_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && (32'(eidx_ff) < TABLE_DEPTH))
         tbl_mem[eidx_ff[TIDX_W-1:0]] <= dval_ff;
      if (cmd.tbl_rd)
         tbl_q_ff <= tbl_mem[mod_ff[TIDX_W-1:0]];
   end

   // release time, saturating
   logic [TIME_W:0]   rel_sum;
   logic [TIME_W-1:0] rel_sat;

   always_comb begin
      rel_sum = {1'b0, now_ff} + (TIME_W+1)'(tbl_q_ff);
      rel_sat = rel_sum[TIME_W] ? '1 : rel_sum[TIME_W-1:0];
   end

   // occupancy and arrival counter
   logic [OCC_W-1:0] occ_ff;
   logic [ORD_W-1:0] arr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         arr_ff <= '0;
      end else if (cmd.q_push) begin
         occ_ff <= occ_ff + OCC_W'(1);
         arr_ff <= arr_ff + ORD_W'(1);
      end else if (cmd.q_move) begin
         occ_ff <= occ_ff - OCC_W'(1);
      end
   end

   // queue memory, one write and one registered read port
   q_entry_type       q_mem [QUEUE_DEPTH];
   q_entry_type       q_rd_ff;
   q_entry_type       q_wr_data;
   logic [QIDX_W-1:0] q_wr_addr;
   logic [QIDX_W-1:0] best_slot_ff;

   always_comb begin
      if (cmd.q_push) begin
         q_wr_addr = occ_ff[QIDX_W-1:0];
         q_wr_data = '{rel: rel_sat, id: pid_ff, order: arr_ff};
      end else begin
         q_wr_addr = best_slot_ff;
         q_wr_data = q_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_push || cmd.q_move)
         q_mem[q_wr_addr] <= q_wr_data;
      if (cmd.q_rd)
         q_rd_ff <= q_mem[cmd.q_addr];
   end

   // head scan: compare the entry read in the previous cycle with the best so far
   logic              cmp_vld_ff;
   logic [QIDX_W-1:0] cmp_slot_ff;
   q_entry_type       best_ff;
   logic [ORD_W-1:0]  ord_diff;
   logic              is_earlier;

   always_comb begin
      ord_diff   = q_rd_ff.order - best_ff.order;
      is_earlier = (q_rd_ff.rel < best_ff.rel) ||
                   ((q_rd_ff.rel == best_ff.rel) && ord_diff[ORD_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset)
         cmp_vld_ff <= 1'b0;
      else
         cmp_vld_ff <= cmd.scan_cmp;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_cmp)
         cmp_slot_ff <= cmd.q_addr;
      if (cmp_vld_ff && ((cmp_slot_ff == '0) || is_earlier)) begin
         best_ff      <= q_rd_ff;
         best_slot_ff <= cmp_slot_ff;
      end
   end

   // wait until the head's release
   logic [TIME_W-1:0] wait_diff;
   logic [WAIT_W-1:0] wait_val;

   always_comb begin
      wait_diff = best_ff.rel - now_ff;
      if (occ_ff == '0)
         wait_val = WAIT_EMPTY;
      else if (best_ff.rel <= now_ff)
         wait_val = '0;
      else if (wait_diff[TIME_W-1:WAIT_W] != '0)
         wait_val = WAIT_EMPTY;
      else
         wait_val = wait_diff[WAIT_W-1:0];
   end

   // result register
   logic              rsp_vld_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [WAIT_W-1:0] rsp_wait_ff;
   logic              rsp_last_ff;
   logic [ID_W-1:0]   id_sel;

   always_comb begin
      case (cmd.emit_kind)
         KIND_ACCEPTED, KIND_DROPPED: id_sel = pid_ff;
         KIND_RELEASED:               id_sel = best_ff.id;
         default:                     id_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_vld_ff <= 1'b0;
      else if (cmd.emit)
         rsp_vld_ff <= 1'b1;
      else if (rsp_tready)
         rsp_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_id_ff   <= id_sel;
         rsp_wait_ff <= (cmd.emit_kind == KIND_WAIT) ? wait_val : '0;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   // status
   always_comb begin
      status.occ      = occ_ff;
      status.full     = 32'(occ_ff) >= QUEUE_DEPTH;
      status.due      = best_ff.rel <= now_ff;
      status.out_free = !rsp_vld_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_wait_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/tddq_ctrl.sv
// tddq_ctrl: state machine sequencing loads, arrivals and polls
// drives the datapath by command struct; depends on tddq_pkg
`default_nettype none

module tddq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tddq_pkg::RTYPE_W-1:0]  req_type,
   input  wire tddq_pkg::status_type          status,
   output tddq_pkg::cmd_type                  cmd
);
   import tddq_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LOAD     = 4'd1;
   localparam logic [3:0] S_ARR      = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_TRD      = 4'd4;
   localparam logic [3:0] S_QWR      = 4'd5;
   localparam logic [3:0] S_SCAN     = 4'd6;
   localparam logic [3:0] S_SCAN_END = 4'd7;
   localparam logic [3:0] S_DECIDE   = 4'd8;
   localparam logic [3:0] S_MOVE     = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   logic [OCC_W-1:0] tail;
   logic             scan_last;

   always_comb begin
      tail      = status.occ - OCC_W'(1);
      scan_last = (OCC_W'(ctr_ff[QIDX_W-1:0]) == tail);
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ctr_in     = ctr_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ctr_in     = '0;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               case (req_type)
                  REQ_LOAD:    state_in = S_LOAD;
                  REQ_ARRIVAL: state_in = S_ARR;
                  REQ_POLL:    state_in = (status.occ == '0) ? S_DECIDE : S_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.tbl_wr    = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_LOADED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ARR: begin
            if (status.full) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_DROPPED;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         // one quotient bit a cycle
         S_DIV: begin
            cmd.div_step = 1'b1;
            ctr_in       = ctr_ff + CTR_W'(1);
            if (ctr_ff == CTR_W'(DIV_STEPS - 1))
               state_in = S_TRD;
         end
         S_TRD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_QWR;
         end
         S_QWR: begin
            if (status.out_free) begin
               cmd.q_push    = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ACCEPTED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         // read one slot a cycle, compared in the cycle after
         S_SCAN: begin
            cmd.q_rd     = 1'b1;
            cmd.scan_cmp = 1'b1;
            cmd.q_addr   = ctr_ff[QIDX_W-1:0];
            ctr_in       = ctr_ff + CTR_W'(1);
            if (scan_last)
               state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctr_in = '0;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if ((status.occ != '0) && status.due) begin
                  cmd.emit_kind = KIND_RELEASED;
                  cmd.q_rd      = 1'b1;
                  cmd.q_addr    = tail[QIDX_W-1:0];
                  state_in      = S_MOVE;
               end else begin
                  cmd.emit_kind = KIND_WAIT;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         // tail entry fills the released slot
         S_MOVE: begin
            cmd.q_move = 1'b1;
            ctr_in     = '0;
            state_in   = (status.occ == OCC_W'(1)) ? S_DECIDE : S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/trace_driven_delay_queue.sv
// trace_driven_delay_queue: top level of the link delay emulator
// ties tddq_ctrl to tddq_datapath; depends on tddq_pkg
//
// usage:
//   req channel: one transfer per request; req_tuser is the request kind
//   (load table entry, packet arrival, poll). rsp channel: one transfer per
//   result; rsp_tuser is the result kind, rsp_tlast marks the final result
//   of a request. csr port: write interval, base time and entry count while idle.
// sequencing (one request in flight at a time):
//   load writes the table entry and emits its result; an arrival into a full
//   queue is dropped without division; an accepted arrival runs the 48-step
//   bit-serial divider that picks the table entry, then reads the table and
//   writes the queue. poll: an empty queue gives the wait report without a
//   head search; otherwise the first result follows a head search with one
//   queue memory read per slot, and each further result follows a slot move
//   and a rescan of the remaining slots.
// the result register lets the next request enter while the last result of
// the previous one waits; a stalled receiver holds results and the sequencer
// waits before producing another.
// reset clears the queue occupancy and arrival counter and presets the config
// registers; the delay table is left as is and must be loaded before arrivals use it.
`default_nettype none

module trace_driven_delay_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [tddq_pkg::CSR_A_W-1:0]  csr_addr,
   input  wire logic [tddq_pkg::CSR_D_W-1:0]  csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // now_ms, packet_id, delay_value, entry_index, zero fill
   input  wire logic [tddq_pkg::REQ_D_W-1:0]  req_tdata,
   // req_type
   input  wire logic [tddq_pkg::RTYPE_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // packet_id_res, wait_ms
   output logic [tddq_pkg::RSP_D_W-1:0]       rsp_tdata,
   // result_kind
   output logic [tddq_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);
   import tddq_pkg::*;

   cmd_type    cmd;
   status_type status;

   tddq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   tddq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: rtl/tddq_checker.sv
// tddq_checker: port level assertions for the delay queue, bound to the top
// depends on tddq_pkg
`default_nettype none

module tddq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [tddq_pkg::RSP_D_W-1:0]  rsp_tdata,
   input wire logic [tddq_pkg::KIND_W-1:0]   rsp_tuser,
   input wire logic                          rsp_tlast
);
   import tddq_pkg::*;

   // stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // stalled result keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // only released packets are followed by more results of the same request
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_RELEASED)))
      else $error("last flag does not match result kind");

   // wait report carries no packet handle, other kinds carry no wait
   a_field_use: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_WAIT) ? (rsp_tdata[15:0] == '0)
                                               : (rsp_tdata[31:16] == '0)))
      else $error("unused result field not zero");

endmodule

bind trace_driven_delay_queue tddq_checker u_tddq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
